// File: hdl/assert_macros.svh
// Assertion macros shared by the search block; clocked on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TWSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/twss_pkg.sv
// Constants, types and helpers of the wildcard substring search block.
package twss_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int MAX_PATTERN  = 16;
	localparam int LEN_CAP      = (MAX_PATTERN < WINDOW_DEPTH) ? MAX_PATTERN : WINDOW_DEPTH;
	localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int CFG_W        = 64;
	localparam int IDX_W        = 2;
	localparam int OFFSET_W     = 32;

	typedef logic [7:0] byte_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_PAT_LOW  = 2'd0;
	localparam reg_idx_t REG_PAT_HIGH = 2'd1;
	localparam reg_idx_t REG_PAT_LEN  = 2'd2;

	localparam byte_t WILDCARD   = 8'h30;
	localparam byte_t DIGIT_LOW  = 8'h31;
	localparam byte_t DIGIT_HIGH = 8'h35;
	localparam byte_t UPPER_A    = 8'h41;
	localparam byte_t UPPER_Z    = 8'h5A;
	localparam byte_t CASE_STEP  = 8'h20;

	// Map upper-case ASCII letters to lower case, pass everything else.
	function automatic byte_t fold_case(byte_t c);
		byte_t r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_STEP;
		end
		return r;
	endfunction

endpackage

// File: hdl/tone_wildcard_substring_search_top.sv
// Streaming case-insensitive substring search with a digit wildcard.
//
// Text bytes enter on the s_ channel, one per beat, s_tlast on the final byte.
// Each text gives exactly one result on the m_ channel: m_tuser[0] = found and
// m_tdata = offset of the match start (0 when not found). A match is reported
// on the beat that completes it; later bytes of that text are dropped until
// the beat with s_tlast, which readies the block for the next text.
// The pattern is loaded through cfg_we / cfg_index / cfg_data between texts:
// index 0 pattern bytes 0-7, index 1 bytes 8-15, index 2 pattern length.
// Throughput: one byte per cycle, unless a byte that gives a result waits on a stalled
// m_tready. All 16 window positions are compared in parallel between the input register
// and the result register, and the result register drives m_tvalid.
// If m_tready is low while a result waits, one more byte is taken into the
// input register, and bytes that give no result keep flowing; a byte that
// would give a result holds there until the waiting result is taken.
// Reset clears the pattern registers (empty pattern), window and counters.
`include "assert_macros.svh"

module tone_wildcard_substring_search_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  twss_pkg::reg_idx_t              cfg_index,
	input  logic [twss_pkg::CFG_W-1:0]      cfg_data,
	// text input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  twss_pkg::byte_t                 s_tdata,   // [7:0] text_byte
	input  logic                            s_tlast,   // text_last
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [twss_pkg::OFFSET_W-1:0]   m_tdata,   // [31:0] match_offset
	output logic [0:0]                      m_tuser    // [0] found
);
	import twss_pkg::*;

	localparam int PAT_W   = 8 * WINDOW_DEPTH;
	localparam int SHIFT_W = LEN_W + 3;

	// configuration
	logic [CFG_W-1:0] pat_low_q;
	logic [CFG_W-1:0] pat_high_q;
	logic [LEN_W-1:0] pat_len_q;

	// input register
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// text state
	byte_t                window_q [WINDOW_DEPTH];
	logic [OFFSET_W-1:0]  position_q;
	logic [OFFSET_W-1:0]  start_bound_q;
	logic                 finished_q;

	// result register
	logic                 out_valid_q;
	logic                 found_q;
	logic [OFFSET_W-1:0]  offset_q;

	// search logic
	byte_t                window_new [WINDOW_DEPTH];
	logic [LEN_W-1:0]     len;
	logic [PAT_W-1:0]     pat_vec;
	logic [PAT_W-1:0]     rev_vec;
	logic [PAT_W-1:0]     aligned_vec;
	logic [SHIFT_W-1:0]   shift;
	logic [WINDOW_DEPTH-1:0] in_len;
	logic [WINDOW_DEPTH-1:0] is_wc;
	logic [WINDOW_DEPTH-1:0] eq;
	logic [WINDOW_DEPTH-1:0] prefix_bit;
	logic                 prefix_ok;
	logic                 full_ok;
	logic [OFFSET_W-1:0]  pos_new;
	logic [OFFSET_W-1:0]  len_ext;
	logic [OFFSET_W-1:0]  cand_s;
	logic [OFFSET_W-1:0]  hit_offset;
	logic                 checked;
	logic                 hit;
	logic                 jump;
	logic                 emit;
	logic                 adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the length to the window depth
	assign len = (pat_len_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : pat_len_q;

	always_comb begin
		window_new[0] = byte_s1;
		for (int j = 1; j < WINDOW_DEPTH; j++) begin
			window_new[j] = window_q[j-1];
		end
	end

	// line the pattern up with the window: window slot j meets pattern byte len-1-j
	assign pat_vec = PAT_W'({pat_high_q, pat_low_q});
	assign shift   = {LEN_W'(WINDOW_DEPTH) - len, 3'b000};

	always_comb begin
		for (int m = 0; m < WINDOW_DEPTH; m++) begin
			rev_vec[8*m +: 8] = pat_vec[8*(WINDOW_DEPTH-1-m) +: 8];
		end
	end

	assign aligned_vec = rev_vec >> shift;

	always_comb begin
		byte_t pb;
		byte_t tb;
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			pb        = aligned_vec[8*j +: 8];
			tb        = window_new[j];
			in_len[j] = LEN_W'(j) < len;
			is_wc[j]  = in_len[j] && (pb == WILDCARD);
			if (pb == WILDCARD) begin
				eq[j] = (tb >= DIGIT_LOW) && (tb <= DIGIT_HIGH);
			end else begin
				eq[j] = fold_case(pb) == fold_case(tb);
			end
		end
		// the part before the first wildcard sits above every wildcard slot
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			prefix_bit[j] = in_len[j] && !is_wc[j] &&
				((is_wc >> (j + 1)) == '0);
		end
	end

	assign prefix_ok = &(~prefix_bit | eq);
	assign full_ok   = &(~in_len | eq);

	assign pos_new    = position_q + OFFSET_W'(1);
	assign len_ext    = OFFSET_W'(len);
	assign cand_s     = pos_new - len_ext;
	assign checked    = (len != '0) && (pos_new >= len_ext) && (cand_s >= start_bound_q);
	assign hit        = (len == '0) || (checked && prefix_ok && full_ok);
	assign jump       = checked && prefix_ok && !full_ok;
	assign hit_offset = (len == '0) ? '0 : cand_s;

	assign emit     = !finished_q && (hit || last_s1);
	assign adv      = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				window_q[j] <= '0;
			end
			position_q    <= '0;
			start_bound_q <= '0;
			finished_q    <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				// end of text: clear for the next one
				for (int j = 0; j < WINDOW_DEPTH; j++) begin
					window_q[j] <= '0;
				end
				position_q    <= '0;
				start_bound_q <= '0;
				finished_q    <= 1'b0;
			end else if (!finished_q) begin
				for (int j = 0; j < WINDOW_DEPTH; j++) begin
					window_q[j] <= window_new[j];
				end
				position_q <= pos_new;
				if (hit) begin
					finished_q <= 1'b1;
				end else if (jump) begin
					start_bound_q <= pos_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			found_q  <= hit;
			offset_q <= hit ? hit_offset : '0;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = offset_q;
	assign m_tuser[0] = found_q;

	`TWSS_ASSERT_NOW(a_no_overwrite, out_valid_q && !m_tready, !(adv && emit), "result overwritten while stalled")
	`TWSS_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "not-found beat with nonzero offset")
	`TWSS_ASSERT_NEXT(a_emit_shows, adv && emit, m_tvalid, "emitted result not presented")
	`TWSS_ASSERT_NEXT(a_text_clear, adv && last_s1, (position_q == '0) && !finished_q && (start_bound_q == '0), "text state not cleared after last byte")

endmodule
